FILE: design/cla_pkg.sv
`default_nettype none

package cla_pkg;

    localparam int LINE_DEPTH  = 64;
    localparam int QUEUE_DEPTH = 2;

    // result kinds
    localparam logic [2:0] K_ECHO    = 3'd0;
    localparam logic [2:0] K_LINE    = 3'd1;
    localparam logic [2:0] K_STATUS  = 3'd2;
    localparam logic [2:0] K_STOP    = 3'd3;
    localparam logic [2:0] K_RESET   = 3'd4;
    localparam logic [2:0] K_TOOLONG = 3'd5;

    // characters with a meaning of their own
    localparam logic [7:0] CH_STATUS = 8'h3F;
    localparam logic [7:0] CH_STOP   = 8'h21;
    localparam logic [7:0] CH_CAN    = 8'h18;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_SP     = 8'h20;

    typedef enum logic [2:0] {
        OP_STATUS,
        OP_STOP,
        OP_RESET,
        OP_CR,
        OP_ERASE,
        OP_LF,
        OP_STORE
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
        logic       from_uart;
    } t_cmd;

endpackage

`default_nettype wire

FILE: design/cla_front.sv
`default_nettype none

module cla_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  wire  [7:0]        i_s_tdata,
    input  wire               i_s_tuser,
    output logic              o_push,
    input  wire               i_push_ready,
    output cla_pkg::t_cmd     o_cmd
);

    logic          r_valid;
    cla_pkg::t_cmd r_cmd;
    cla_pkg::t_cmd w_cmd;
    logic          w_accept;

    always_comb begin
        w_cmd.rx_byte   = i_s_tdata;
        w_cmd.from_uart = i_s_tuser;
        priority if (i_s_tdata == cla_pkg::CH_STATUS) begin
            w_cmd.op = cla_pkg::OP_STATUS;
        end else if (i_s_tdata == cla_pkg::CH_STOP) begin
            w_cmd.op = cla_pkg::OP_STOP;
        end else if (i_s_tdata == cla_pkg::CH_CAN) begin
            w_cmd.op = cla_pkg::OP_RESET;
        end else if (i_s_tdata == cla_pkg::CH_CR) begin
            w_cmd.op = cla_pkg::OP_CR;
        end else if (i_s_tdata == cla_pkg::CH_BS || i_s_tdata == cla_pkg::CH_DEL) begin
            w_cmd.op = cla_pkg::OP_ERASE;
        end else if (i_s_tdata == cla_pkg::CH_LF) begin
            w_cmd.op = cla_pkg::OP_LF;
        end else begin
            w_cmd.op = cla_pkg::OP_STORE;
        end
    end

    assign o_s_tready = !r_valid || i_push_ready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= w_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: design/cla_queue.sv
`default_nettype none

module cla_queue #(
    parameter int DEPTH = cla_pkg::QUEUE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    output logic              o_ready,
    input  cla_pkg::t_cmd     i_cmd,
    input  wire               i_pop,
    output logic              o_valid,
    output cla_pkg::t_cmd     o_cmd
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    cla_pkg::t_cmd r_buf [DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_ready = r_cnt != CW'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_buf[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: design/cla_back.sv
`default_nettype none

module cla_back #(
    parameter int LINE_DEPTH = cla_pkg::LINE_DEPTH
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_term,
    input  wire               i_cmd_valid,
    input  cla_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_m_tvalid,
    input  wire               i_m_tready,
    output logic [7:0]        o_data,
    output logic [2:0]        o_kind,
    output logic              o_copy,
    output logic              o_last
);

    localparam int LW = $clog2(LINE_DEPTH);

    typedef enum logic [1:0] {S_IDLE, S_ECHO, S_LREAD, S_LEMIT} t_state;

    t_state        r_state, n_state;
    logic [LW-1:0] r_len, n_len;
    logic [LW-1:0] r_idx, n_idx;
    logic          r_echo_sp, n_echo_sp;
    logic          r_copy, n_copy;
    logic          r_out_valid, n_out_valid;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_data, n_data;
    logic          r_out_copy, n_out_copy;
    logic          r_out_last, n_out_last;
    logic [7:0]    r_rd_data;
    logic [7:0]    r_mem [LINE_DEPTH];

    logic          w_slot;
    logic          w_store;
    logic          w_emit;
    logic [2:0]    e_kind;
    logic [7:0]    e_data;
    logic          e_copy;
    logic          e_last;

    // output register is free or drains this cycle
    assign w_slot  = !r_out_valid || i_m_tready;
    assign o_pop   = (r_state == S_IDLE) && i_cmd_valid && w_slot;
    assign w_store = o_pop && (i_cmd.op == cla_pkg::OP_STORE)
                     && (r_len != LW'(LINE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_len] <= i_cmd.rx_byte;
        end
        if (r_state == S_LREAD) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_idx       = r_idx;
        n_echo_sp   = r_echo_sp;
        n_copy      = r_copy;
        n_out_valid = r_out_valid && !i_m_tready;
        n_kind      = r_kind;
        n_data      = r_data;
        n_out_copy  = r_out_copy;
        n_out_last  = r_out_last;
        w_emit      = 1'b0;
        e_kind      = cla_pkg::K_ECHO;
        e_data      = '0;
        e_copy      = 1'b0;
        e_last      = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    unique case (i_cmd.op)
                        cla_pkg::OP_STATUS: begin
                            w_emit = 1'b1;
                            e_kind = cla_pkg::K_STATUS;
                        end
                        cla_pkg::OP_STOP: begin
                            w_emit = 1'b1;
                            e_kind = cla_pkg::K_STOP;
                        end
                        cla_pkg::OP_RESET: begin
                            w_emit = 1'b1;
                            e_kind = cla_pkg::K_RESET;
                        end
                        cla_pkg::OP_CR: begin
                        end
                        cla_pkg::OP_ERASE: begin
                            if (r_len != '0) begin
                                n_len = r_len - LW'(1);
                                if (i_term) begin
                                    // backspace, space, backspace
                                    w_emit    = 1'b1;
                                    e_data    = cla_pkg::CH_BS;
                                    e_last    = 1'b0;
                                    n_echo_sp = 1'b1;
                                    n_state   = S_ECHO;
                                end
                            end
                        end
                        cla_pkg::OP_LF: begin
                            n_copy = i_cmd.from_uart && i_term;
                            n_idx  = '0;
                            if (i_term) begin
                                w_emit = 1'b1;
                                e_data = cla_pkg::CH_LF;
                                e_last = (r_len == '0);
                            end
                            if (r_len != '0) begin
                                n_state = S_LREAD;
                            end
                        end
                        cla_pkg::OP_STORE: begin
                            if (r_len == LW'(LINE_DEPTH - 1)) begin
                                n_len  = '0;
                                w_emit = 1'b1;
                                e_kind = cla_pkg::K_TOOLONG;
                            end else begin
                                n_len = r_len + LW'(1);
                                if (i_term) begin
                                    w_emit = 1'b1;
                                    e_data = i_cmd.rx_byte;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ECHO: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    if (r_echo_sp) begin
                        e_data    = cla_pkg::CH_SP;
                        e_last    = 1'b0;
                        n_echo_sp = 1'b0;
                    end else begin
                        e_data  = cla_pkg::CH_BS;
                        n_state = S_IDLE;
                    end
                end
            end
            S_LREAD: begin
                n_state = S_LEMIT;
            end
            S_LEMIT: begin
                if (w_slot) begin
                    w_emit = 1'b1;
                    e_kind = cla_pkg::K_LINE;
                    e_data = r_rd_data;
                    e_copy = r_copy;
                    e_last = (r_idx == r_len - LW'(1));
                    if (e_last) begin
                        n_len   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + LW'(1);
                        n_state = S_LREAD;
                    end
                end
            end
        endcase
        if (w_emit) begin
            n_out_valid = 1'b1;
            n_kind      = e_kind;
            n_data      = e_data;
            n_out_copy  = e_copy;
            n_out_last  = e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_idx      <= n_idx;
        r_echo_sp  <= n_echo_sp;
        r_copy     <= n_copy;
        r_kind     <= n_kind;
        r_data     <= n_data;
        r_out_copy <= n_out_copy;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_data     = r_data;
    assign o_kind     = r_kind;
    assign o_copy     = r_out_copy;
    assign o_last     = r_out_last;

endmodule

`default_nettype wire

FILE: design/command_line_assembler.sv
// Command line assembler: takes received bytes tagged with their source port and
// builds command lines. The realtime bytes '?', '!' and 0x18 give one status, stop
// or soft-reset result at once and are never stored; carriage return is dropped;
// backspace and DEL erase the last character (echoed as BS, SP, BS in terminal
// mode); line feed emits the stored line one character per result and clears it.
// A byte that would make the line reach LINE_DEPTH characters clears the line
// and gives a line-too-long result. Every result group ends with tlast. A front
// stage classifies each byte and hands it through a short queue to the back
// sequencer, so bytes keep arriving while results wait. Most bytes need only S_IDLE;
// a line feed sends each stored character through S_LREAD, the registered read of
// the line memory, then S_LEMIT, which loads the output register. terminal_mode is
// to be written through the cfg port only while no byte is in flight; the user is
// bound to this, the block itself does not enforce it.
`default_nettype none

module command_line_assembler #(
    parameter int LINE_DEPTH  = cla_pkg::LINE_DEPTH,
    parameter int QUEUE_DEPTH = cla_pkg::QUEUE_DEPTH
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire         i_cfg_data,    // terminal_mode
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [7:0]  i_s_tdata,     // rx_byte
    input  wire         i_s_tuser,     // from_uart
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata,     // data
    output logic [3:0]  o_m_tuser,     // kind[2:0], copy_to_debug
    output logic        o_m_tlast
);

    logic          r_term;
    logic          w_push;
    logic          w_push_ready;
    cla_pkg::t_cmd w_front_cmd;
    logic          w_q_valid;
    logic          w_pop;
    cla_pkg::t_cmd w_q_cmd;
    logic [2:0]    w_kind;
    logic          w_copy;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term <= 1'b0;
        end else if (i_cfg_valid) begin
            r_term <= i_cfg_data;
        end
    end

    cla_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .o_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .o_push       (w_push),
        .i_push_ready (w_push_ready),
        .o_cmd        (w_front_cmd)
    );

    cla_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_ready (w_push_ready),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd)
    );

    cla_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_term      (r_term),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_pop       (w_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_data      (o_m_tdata),
        .o_kind      (w_kind),
        .o_copy      (w_copy),
        .o_last      (o_m_tlast)
    );

    assign o_m_tuser = {w_copy, w_kind};

endmodule

`default_nettype wire

FILE: design/cla_checker.sv
`default_nettype none

module cla_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        o_m_tvalid,
    input wire        i_m_tready,
    input wire [7:0]  o_m_tdata,
    input wire [3:0]  o_m_tuser,
    input wire        o_m_tlast
);

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tuser[2:0] == cla_pkg::K_ECHO
            || o_m_tuser[2:0] == cla_pkg::K_LINE || o_m_tuser[2:0] == cla_pkg::K_STATUS
            || o_m_tuser[2:0] == cla_pkg::K_STOP || o_m_tuser[2:0] == cla_pkg::K_RESET
            || o_m_tuser[2:0] == cla_pkg::K_TOOLONG)
        else $error("unknown result kind");

    // requests and errors carry no character and end their group
    a_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[2:0] != cla_pkg::K_ECHO
            && o_m_tuser[2:0] != cla_pkg::K_LINE |-> o_m_tdata == 8'h00 && o_m_tlast)
        else $error("request result with data or without last");

    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[3] |-> o_m_tuser[2:0] == cla_pkg::K_LINE)
        else $error("debug copy flag on a non-line result");

endmodule

bind command_line_assembler cla_checker u_cla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire
